FILE: rtl/ssd_pkg.sv
// Package for the SSD stereo disparity block: register indexes, field widths and reset values.
package ssd_pkg;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_MAX_DISPARITY = 2'd2,
    CFG_WINDOW_HALF   = 2'd3
  } cfg_index_t;

  localparam int PIX_W   = 8;
  localparam int DISP_W  = 6;
  localparam int COST_W  = 24;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;

  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 16;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [6:0]  RST_MAX_DISPARITY = 7'd32;
  localparam logic [2:0]  RST_WINDOW_HALF   = 3'd2;

endpackage

FILE: rtl/ssd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ssd_stereo_disparity_left.sv
// Top level of the SSD block-matching stereo disparity block, left image as reference.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | left_pixel, right_pixel, frame_start
//  out     | out_valid / out_stall| disparity, match_cost, out_row, out_col, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A pixel with no result is only stored. A pixel with a result sums, for each shift
// tested, the squared differences over the (2h+1)^2 window elements; one squared
// difference is formed per cycle, set by the single read port of each line store.
// Reset clears counters and control, loads config; line stores and datapath are not cleared.
// A result waits in the output register under out_stall while the next pixel is taken.
module ssd_stereo_disparity_left import ssd_pkg::*; #(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_DISPARITY   = 64,
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   left_pixel,
  input  logic [PIX_W-1:0]   right_pixel,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DISP_W-1:0]  disparity,
  output logic [COST_W-1:0]  match_cost,
  output logic [POS_W-1:0]   out_row,
  output logic [POS_W-1:0]   out_col,
  output logic               frame_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int LINES = 2 * MAX_HALF_WINDOW + 1;
  localparam int DEPTH = LINES * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int KW    = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int MW    = $clog2(MAX_DISPARITY + 1);
  localparam int SW    = $clog2(LINES * LINES * 65025 + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_WAIT} state_t;

  state_t state;

  logic [10:0] image_width, image_height;
  logic [6:0]  max_disparity;
  logic [2:0]  window_half;

  logic [CW-1:0]    column_count;
  logic [POS_W-1:0] row_count;
  logic [LW-1:0]    line_count;

  // Pixel under evaluation.
  logic [CW-1:0]    cur_col;
  logic [POS_W-1:0] cur_row;
  logic [LW-1:0]    cur_line;
  logic [KW-1:0]    cur_h;
  logic [MW-1:0]    d_last;
  logic             cur_end;

  logic [MW-1:0] d_cnt;
  logic [KW-1:0] ky, kx;

  logic          p1_valid, p1_first, p1_last, p1_final;
  logic [MW-1:0] p1_d;
  logic          p2_valid, p2_first, p2_last, p2_final;
  logic [MW-1:0] p2_d;
  logic [15:0]   sq;
  logic [SW-1:0] acc, best_cost;
  logic [MW-1:0] best_d;

  logic [PIX_W-1:0] l_rdata, r_rdata;
  logic [AW-1:0]    waddr, l_raddr, r_raddr;
  logic             accept;

  // Clamped register values.
  logic [31:0] w_eff, hgt_eff, md_eff, h_eff;

  always_comb begin
    w_eff = 32'(image_width);
    if (w_eff < 32'(MIN_SIZE)) w_eff = 32'(MIN_SIZE);
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    hgt_eff = 32'(image_height);
    if (hgt_eff < 32'(MIN_SIZE)) hgt_eff = 32'(MIN_SIZE);
    if (hgt_eff > 32'(MAX_HEIGHT)) hgt_eff = 32'(MAX_HEIGHT);
    md_eff = 32'(max_disparity);
    if (md_eff < 32'd1) md_eff = 32'd1;
    if (md_eff > 32'(MAX_DISPARITY)) md_eff = 32'(MAX_DISPARITY);
    h_eff = 32'(window_half);
    if (h_eff > 32'(MAX_HALF_WINDOW)) h_eff = 32'(MAX_HALF_WINDOW);
  end

  // Position of the incoming pixel and the counters after it.
  logic [31:0] ca, ra, la, cb, rb, lb, cn, rn, ln, lim;
  logic        eval;

  always_comb begin
    ca = frame_start ? 32'd0 : 32'(column_count);
    ra = frame_start ? 32'd0 : 32'(row_count);
    la = frame_start ? 32'd0 : 32'(line_count);
    cb = ca;
    rb = ra;
    lb = la;
    if (ca >= w_eff) begin
      cb = 32'd0;
      rb = ra + 32'd1;
      lb = (la == 32'(LINES - 1)) ? 32'd0 : la + 32'd1;
    end
    if (rb >= hgt_eff) begin
      rb = 32'd0;
      lb = 32'd0;
    end
    cn = cb + 32'd1;
    rn = rb;
    ln = lb;
    if (cn >= w_eff) begin
      cn = 32'd0;
      rn = rb + 32'd1;
      ln = (lb == 32'(LINES - 1)) ? 32'd0 : lb + 32'd1;
      if (rn >= hgt_eff) begin
        rn = 32'd0;
        ln = 32'd0;
      end
    end
    eval = (rb >= 2 * h_eff) && (cb >= 2 * h_eff);
    lim  = cb - 2 * h_eff;
    if (lim > md_eff - 32'd1) lim = md_eff - 32'd1;
  end

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign waddr     = AW'(lb * 32'(MAX_WIDTH) + cb);

  // Read addresses for the current window element and shift.
  logic [31:0] kk, yline, xl, xr;

  always_comb begin
    kk    = 2 * 32'(cur_h) - 32'(ky);
    yline = (32'(cur_line) >= kk) ? 32'(cur_line) - kk : 32'(cur_line) + 32'(LINES) - kk;
    xl    = 32'(cur_col) - 2 * 32'(cur_h) + 32'(kx);
    xr    = xl - 32'(d_cnt);
  end

  assign l_raddr = AW'(yline * 32'(MAX_WIDTH) + xl);
  assign r_raddr = AW'(yline * 32'(MAX_WIDTH) + xr);

  ssd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (left_pixel),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  ssd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (right_pixel),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  logic [PIX_W-1:0] adiff;
  logic [SW-1:0]    acc_next;
  logic             k_end, row_end;

  assign adiff    = (l_rdata >= r_rdata) ? l_rdata - r_rdata : r_rdata - l_rdata;
  assign acc_next = (p2_first ? '0 : acc) + SW'(sq);
  assign row_end  = (kx == 2 * cur_h);
  assign k_end    = row_end && (ky == 2 * cur_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      line_count    <= '0;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      max_disparity <= RST_MAX_DISPARITY;
      window_half   <= RST_WINDOW_HALF;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
          CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          CFG_MAX_DISPARITY: max_disparity <= cfg_data[6:0];
          CFG_WINDOW_HALF:   window_half   <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (state == ST_WAIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      p1_valid <= (state == ST_RUN);
      p2_valid <= p1_valid;
      p2_first <= p1_first;
      p2_last  <= p1_last;
      p2_final <= p1_final;
      p2_d     <= p1_d;
      sq       <= 16'(adiff) * 16'(adiff);

      // A shift's cost is final on its last element; the smallest shift wins ties.
      if (p2_valid) begin
        acc <= acc_next;
        if (p2_last && (p2_d == '0 || acc_next < best_cost)) begin
          best_cost <= acc_next;
          best_d    <= p2_d;
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            column_count <= CW'(cn);
            row_count    <= POS_W'(rn);
            line_count   <= LW'(ln);
            cur_col      <= CW'(cb);
            cur_row      <= POS_W'(rb);
            cur_line     <= LW'(lb);
            cur_h        <= KW'(h_eff);
            d_last       <= MW'(lim);
            cur_end      <= (rb == hgt_eff - 32'd1) && (cb == w_eff - 32'd1);
            d_cnt        <= '0;
            ky           <= '0;
            kx           <= '0;
            if (eval) begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          p1_first <= (ky == '0) && (kx == '0);
          p1_last  <= k_end;
          p1_final <= k_end && (d_cnt == d_last);
          p1_d     <= d_cnt;
          if (row_end) begin
            kx <= '0;
            if (k_end) begin
              ky <= '0;
              if (d_cnt == d_last) begin
                state <= ST_DRAIN;
              end else begin
                d_cnt <= d_cnt + 1'b1;
              end
            end else begin
              ky <= ky + 1'b1;
            end
          end else begin
            kx <= kx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (p2_valid && p2_final) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid || !out_stall) begin
            disparity  <= DISP_W'(best_d);
            match_cost <= COST_W'(best_cost);
            out_row    <= POS_W'(32'(cur_row) - 32'(cur_h));
            out_col    <= POS_W'(32'(cur_col) - 32'(cur_h));
            frame_end  <= cur_end;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ssd_checker.sv
// Port-level checker for the SSD stereo disparity block, bound to the top level.
module ssd_checker import ssd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DISP_W-1:0] disparity,
  input logic [COST_W-1:0] match_cost,
  input logic [POS_W-1:0]  out_row,
  input logic [POS_W-1:0]  out_col,
  input logic              frame_end
);

  // A request held under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(disparity) && $stable(match_cost)
      && $stable(out_row) && $stable(out_col) && $stable(frame_end))
    else $error("result changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A new result only appears after the block has been busy working on it.
  a_busy_before_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without evaluation");

  // The winning shift never reaches past column zero.
  a_shift_in_image: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 10'(disparity) <= out_col)
    else $error("shift exceeds column");

endmodule

bind ssd_stereo_disparity_left ssd_checker u_ssd_checker (.*);
